### rtl/imac_pkg.sv
// imac_pkg: shared types, constants and tables for the ima adpcm codec core
// used by imac_if, imac_div, imac_mul and the codec core; no dependencies
`timescale 1ns / 1ps

package imac_pkg;

    // field widths
    localparam int PCM_W  = 16;
    localparam int CODE_W = 4;
    localparam int IDX_W  = 7;
    localparam int STEP_W = 15;
    localparam int CFG_W  = 16;
    localparam int ACC_W  = STEP_W + 3;

    localparam logic [IDX_W-1:0]         INDEX_MAX = 7'd88;
    localparam logic signed [PCM_W+1:0]  PCM_MAX   = 18'sd32767;
    localparam logic signed [PCM_W+1:0]  PCM_MIN   = -18'sd32768;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_MODE      = 2'd0,
        CFG_INIT_PRED = 2'd1,
        CFG_INIT_IDX  = 2'd2,
        CFG_INIT_STEP = 2'd3
    } t_cfg_reg;

    // operating mode
    typedef enum logic {
        MODE_ENC = 1'b0,
        MODE_DEC = 1'b1
    } t_mode;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_DIFF,
        S_BITS,
        S_DRAIN,
        S_COMMIT
    } t_state;

    // control for the serial quotient unit
    typedef struct packed {
        logic load;
        logic first;
        logic shift;
    } t_div_ctl;

    // control for the serial shift-add multiplier
    typedef struct packed {
        logic clr;
        logic en;
        logic qbit;
    } t_mul_ctl;

    // index adjustment per code magnitude
    function automatic logic signed [4:0] f_index_adjust(input logic [2:0] mag);
        logic signed [4:0] adj;
        case (mag)
            3'd4:    adj = 5'sd2;
            3'd5:    adj = 5'sd4;
            3'd6:    adj = 5'sd6;
            3'd7:    adj = 5'sd8;
            default: adj = -5'sd1;
        endcase
        return adj;
    endfunction

    // step size table, 89 entries
    function automatic logic [STEP_W-1:0] f_step(input logic [IDX_W-1:0] idx);
        logic [STEP_W-1:0] s;
        case (idx)
            7'd0:  s = 15'd7;     7'd1:  s = 15'd8;     7'd2:  s = 15'd9;
            7'd3:  s = 15'd10;    7'd4:  s = 15'd11;    7'd5:  s = 15'd12;
            7'd6:  s = 15'd13;    7'd7:  s = 15'd14;    7'd8:  s = 15'd16;
            7'd9:  s = 15'd17;    7'd10: s = 15'd19;    7'd11: s = 15'd21;
            7'd12: s = 15'd23;    7'd13: s = 15'd25;    7'd14: s = 15'd28;
            7'd15: s = 15'd31;    7'd16: s = 15'd34;    7'd17: s = 15'd37;
            7'd18: s = 15'd41;    7'd19: s = 15'd45;    7'd20: s = 15'd50;
            7'd21: s = 15'd55;    7'd22: s = 15'd60;    7'd23: s = 15'd66;
            7'd24: s = 15'd73;    7'd25: s = 15'd80;    7'd26: s = 15'd88;
            7'd27: s = 15'd97;    7'd28: s = 15'd107;   7'd29: s = 15'd118;
            7'd30: s = 15'd130;   7'd31: s = 15'd143;   7'd32: s = 15'd157;
            7'd33: s = 15'd173;   7'd34: s = 15'd190;   7'd35: s = 15'd209;
            7'd36: s = 15'd230;   7'd37: s = 15'd253;   7'd38: s = 15'd279;
            7'd39: s = 15'd307;   7'd40: s = 15'd337;   7'd41: s = 15'd371;
            7'd42: s = 15'd408;   7'd43: s = 15'd449;   7'd44: s = 15'd494;
            7'd45: s = 15'd544;   7'd46: s = 15'd598;   7'd47: s = 15'd658;
            7'd48: s = 15'd724;   7'd49: s = 15'd796;   7'd50: s = 15'd876;
            7'd51: s = 15'd963;   7'd52: s = 15'd1060;  7'd53: s = 15'd1166;
            7'd54: s = 15'd1282;  7'd55: s = 15'd1411;  7'd56: s = 15'd1552;
            7'd57: s = 15'd1707;  7'd58: s = 15'd1878;  7'd59: s = 15'd2066;
            7'd60: s = 15'd2272;  7'd61: s = 15'd2499;  7'd62: s = 15'd2749;
            7'd63: s = 15'd3024;  7'd64: s = 15'd3327;  7'd65: s = 15'd3660;
            7'd66: s = 15'd4026;  7'd67: s = 15'd4428;  7'd68: s = 15'd4871;
            7'd69: s = 15'd5358;  7'd70: s = 15'd5894;  7'd71: s = 15'd6484;
            7'd72: s = 15'd7132;  7'd73: s = 15'd7845;  7'd74: s = 15'd8630;
            7'd75: s = 15'd9493;  7'd76: s = 15'd10442; 7'd77: s = 15'd11487;
            7'd78: s = 15'd12635; 7'd79: s = 15'd13899; 7'd80: s = 15'd15289;
            7'd81: s = 15'd16818; 7'd82: s = 15'd18500; 7'd83: s = 15'd20350;
            7'd84: s = 15'd22385; 7'd85: s = 15'd24623; 7'd86: s = 15'd27086;
            7'd87: s = 15'd29794; 7'd88: s = 15'd32767;
            default: s = 15'd32767;
        endcase
        return s;
    endfunction

endpackage

### rtl/imac_if.sv
// imac_if: valid/ready channel interfaces for sample words and result words
// depends on imac_pkg for field widths
`timescale 1ns / 1ps

interface imac_in_if
    import imac_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic                     reinit;
    logic signed [PCM_W-1:0]  pcm_in;
    logic [CODE_W-1:0]        code_in;

    modport source (output valid, output reinit, output pcm_in, output code_in,
                    input ready);
    modport sink   (input valid, input reinit, input pcm_in, input code_in,
                    output ready);
endinterface

interface imac_out_if
    import imac_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [CODE_W-1:0]        code_out;
    logic signed [PCM_W-1:0]  pcm_out;

    modport source (output valid, output code_out, output pcm_out, input ready);
    modport sink   (input valid, input code_out, input pcm_out, output ready);
endinterface

### rtl/ima_adpcm_codec_core.sv
// ima_adpcm_codec_core: 4-bit ima adpcm encoder/decoder, top level
// depends on imac_pkg, imac_if, imac_div and imac_mul
`timescale 1ns / 1ps
//
//  channel  | dir | handshake     | word
//  i_in     | in  | valid/ready   | reinit, pcm_in, code_in
//  o_out    | out | valid/ready   | code_out, pcm_out
//  i_cfg_*  | in  | write enable  | register index, write data
//
//  an encode word passes from acceptance to a result in the output register
//  through the difference, three quotient bits, multiplier drain and update, a
//  decode word skips the difference step; the next word is not taken before
//  the sequencer has left the update step and is idle again
//  a new word is accepted whenever the sequencer is idle, even while a result
//  waits in the output register; a stalled output holds the update cycle
//  synchronous active-low reset gives predictor 0, index 0, step 7, mode encode

module ima_adpcm_codec_core
    import imac_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    imac_in_if.sink           i_in,
    imac_out_if.source        o_out,
    input  logic              i_cfg_wr_en,
    input  logic [1:0]        i_cfg_index,
    input  logic [CFG_W-1:0]  i_cfg_wdata
);

    // configuration registers
    logic                     r_mode;
    logic signed [PCM_W-1:0]  r_init_pred;
    logic [IDX_W-1:0]         r_init_idx;
    logic [STEP_W-1:0]        r_init_step;

    // codec state
    logic signed [PCM_W-1:0]  r_pred;
    logic [IDX_W-1:0]         r_idx;
    logic [STEP_W-1:0]        r_step;

    // per-word working registers
    t_state                   r_state;
    t_state                   n_state;
    logic signed [PCM_W-1:0]  r_pcm;
    logic [CODE_W-1:0]        r_code;
    logic [1:0]               r_cnt;
    logic                     r_qbit;
    logic                     r_qvld;

    // output register
    logic                     r_out_vld;
    logic [CODE_W-1:0]        r_out_code;
    logic signed [PCM_W-1:0]  r_out_pcm;

    t_div_ctl                 div_ctl;
    t_mul_ctl                 mul_ctl;
    logic                     div_qbit;
    logic [PCM_W-1:0]         delta;
    logic                     in_acc;
    logic                     out_free;
    logic                     commit;
    logic                     cur_bit;
    logic [1:0]               bit_pos;

    logic [PCM_W:0]           d_pos;
    logic [PCM_W:0]           d_neg;
    logic                     d_sign;
    logic [PCM_W-1:0]         d_mag;

    logic signed [PCM_W+1:0]  pred_ext;
    logic signed [PCM_W+1:0]  pred_sum;
    logic signed [PCM_W-1:0]  n_pred;
    logic signed [4:0]        idx_adj;
    logic [IDX_W+1:0]         idx_sum;
    logic [IDX_W-1:0]         n_idx;

    // handshake
    assign i_in.ready     = (r_state == S_IDLE);
    assign in_acc         = i_in.valid && (r_state == S_IDLE);
    assign out_free       = !r_out_vld || o_out.ready;
    assign commit         = (r_state == S_COMMIT) && out_free;
    assign o_out.valid    = r_out_vld;
    assign o_out.code_out = r_out_code;
    assign o_out.pcm_out  = r_out_pcm;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_state = (r_mode == MODE_DEC) ? S_BITS : S_DIFF;
                end
            end
            S_DIFF: n_state = S_BITS;
            S_BITS: begin
                if (r_cnt == 2'd2) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: n_state = S_COMMIT;
            S_COMMIT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        bit_pos       = 2'd2 - r_cnt;
        div_ctl.load  = (r_state == S_DIFF);
        div_ctl.first = (r_state == S_BITS) && (r_cnt == 2'd0);
        div_ctl.shift = (r_state == S_BITS) && (r_mode == MODE_ENC);
        cur_bit       = (r_mode == MODE_DEC) ? r_code[bit_pos] : div_qbit;
        mul_ctl.clr   = in_acc;
        mul_ctl.en    = r_qvld;
        mul_ctl.qbit  = r_qbit;
    end

    // difference between sample and prediction, both directions in parallel
    always_comb begin
        d_pos  = {r_pcm[PCM_W-1], r_pcm} - {r_pred[PCM_W-1], r_pred};
        d_neg  = {r_pred[PCM_W-1], r_pred} - {r_pcm[PCM_W-1], r_pcm};
        d_sign = d_pos[PCM_W];
        d_mag  = d_sign ? d_neg[PCM_W-1:0] : d_pos[PCM_W-1:0];
    end

    // state update: clamped prediction, clamped index, step from the table
    always_comb begin
        pred_ext = {{2{r_pred[PCM_W-1]}}, r_pred};
        pred_sum = r_code[3] ? (pred_ext - $signed({2'b00, delta}))
                             : (pred_ext + $signed({2'b00, delta}));
        if (pred_sum > PCM_MAX) begin
            n_pred = PCM_MAX[PCM_W-1:0];
        end else if (pred_sum < PCM_MIN) begin
            n_pred = PCM_MIN[PCM_W-1:0];
        end else begin
            n_pred = pred_sum[PCM_W-1:0];
        end
        idx_adj = f_index_adjust(r_code[2:0]);
        idx_sum = {2'b00, r_idx} + {{4{idx_adj[4]}}, idx_adj};
        if (idx_sum[IDX_W+1]) begin
            n_idx = '0;
        end else if (idx_sum[IDX_W:0] > {1'b0, INDEX_MAX}) begin
            n_idx = INDEX_MAX;
        end else begin
            n_idx = idx_sum[IDX_W-1:0];
        end
    end

    imac_div u_div (
        .i_clk  (i_clk),
        .i_ctl  (div_ctl),
        .i_mag  (d_mag),
        .i_step (r_step),
        .o_qbit (div_qbit)
    );

    imac_mul u_mul (
        .i_clk   (i_clk),
        .i_ctl   (mul_ctl),
        .i_step  (r_step),
        .o_delta (delta)
    );

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_ENC;
            r_init_pred <= '0;
            r_init_idx  <= '0;
            r_init_step <= 15'd7;
        end else if (i_cfg_wr_en) begin
            case (t_cfg_reg'(i_cfg_index))
                CFG_MODE:      r_mode      <= i_cfg_wdata[0];
                CFG_INIT_PRED: r_init_pred <= i_cfg_wdata;
                CFG_INIT_IDX:  r_init_idx  <= i_cfg_wdata[IDX_W-1:0];
                CFG_INIT_STEP: r_init_step <= i_cfg_wdata[STEP_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencer and codec state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pred  <= '0;
            r_idx   <= '0;
            r_step  <= 15'd7;
            r_cnt   <= '0;
            r_qvld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_qvld  <= (r_state == S_BITS);
            if (in_acc) begin
                r_cnt <= '0;
                if (i_in.reinit) begin
                    r_pred <= r_init_pred;
                    r_idx  <= r_init_idx;
                    r_step <= r_init_step;
                end
            end else if (r_state == S_BITS) begin
                r_cnt <= r_cnt + 2'd1;
            end
            if (commit) begin
                r_pred <= n_pred;
                r_idx  <= n_idx;
                r_step <= f_step(n_idx);
            end
        end
    end

    // word payload and code assembly
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_pcm  <= i_in.pcm_in;
            r_code <= i_in.code_in;
        end else if (r_state == S_DIFF) begin
            r_code[3] <= d_sign;
        end else if (r_state == S_BITS) begin
            r_code[bit_pos] <= cur_bit;
        end
        r_qbit <= cur_bit;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (commit) begin
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_out_code <= r_code;
            r_out_pcm  <= n_pred;
        end
    end

    // checks
    a_out_from_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> $past(r_state == S_COMMIT))
        else $error("result word appeared without an update cycle");

    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        commit |=> (r_idx <= INDEX_MAX))
        else $error("step index left 0..88 after update");

    a_step_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        commit |=> (r_step != '0))
        else $error("step size zero after table lookup");

    a_bit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BITS) |-> (r_cnt != 2'd3))
        else $error("more than three magnitude bits");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COMMIT && !out_free) |=> (r_state == S_COMMIT))
        else $error("update cycle left while output register full");

endmodule

### rtl/imac_div.sv
// imac_div: restoring quotient unit, one bit of min(7, 4*mag/step) per cycle with shift set
// depends on imac_pkg (widths, t_div_ctl)
`timescale 1ns / 1ps

module imac_div
    import imac_pkg::*;
(
    input  logic              i_clk,
    input  t_div_ctl          i_ctl,
    input  logic [PCM_W-1:0]  i_mag,
    input  logic [STEP_W-1:0] i_step,
    output logic              o_qbit
);

    logic [STEP_W+2:0] r_rem;   // partial remainder, starts at 4*mag
    logic [STEP_W+1:0] r_div;   // shifted divisor, starts at 4*step
    logic              r_ovf;   // quotient would reach 8 or more

    logic ge;
    logic ovf_now;

    // compare against current divisor, and on the first bit against twice it
    always_comb begin
        ge      = r_rem >= {1'b0, r_div};
        ovf_now = i_ctl.first ? (r_rem >= {r_div, 1'b0}) : r_ovf;
        o_qbit  = ovf_now | ge;
    end

    // load, then subtract and shift once per quotient bit
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_rem <= {i_mag, 2'b00};
            r_div <= {i_step, 2'b00};
            r_ovf <= 1'b0;
        end else if (i_ctl.shift) begin
            if (!ovf_now && ge) begin
                r_rem <= r_rem - {1'b0, r_div};
            end
            r_div <= {1'b0, r_div[STEP_W+1:1]};
            r_ovf <= ovf_now;
        end
    end

endmodule

### rtl/imac_mul.sv
// imac_mul: shift-add multiplier, magnitude bits msb first times step size
// depends on imac_pkg (widths, t_mul_ctl)
`timescale 1ns / 1ps

module imac_mul
    import imac_pkg::*;
(
    input  logic              i_clk,
    input  t_mul_ctl          i_ctl,
    input  logic [STEP_W-1:0] i_step,
    output logic [PCM_W-1:0]  o_delta
);

    logic [ACC_W-1:0] r_acc;
    logic [ACC_W-1:0] n_acc;

    // double and add the step when the incoming bit is set
    always_comb begin
        n_acc = {r_acc[ACC_W-2:0], 1'b0}
              + (i_ctl.qbit ? {3'b000, i_step} : {ACC_W{1'b0}});
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.clr) begin
            r_acc <= '0;
        end else if (i_ctl.en) begin
            r_acc <= n_acc;
        end
    end

    // difference is the product shifted right by two
    assign o_delta = r_acc[ACC_W-1:2];

endmodule
